>>> hw/rtl/srt_pkg.sv
// srt_pkg: types, codes and sizes shared by the sorted rectangle table
// used by srt_cell and sorted_rectangle_table; depends on nothing else
package srt_pkg;

	localparam int CAPACITY   = 64;
	localparam int COORD_BITS = 12;
	localparam int CNT_BITS   = $clog2(CAPACITY + 1);

	typedef enum logic [0:0] {
		CMD_INSERT = 1'b0,
		CMD_REMOVE = 1'b1
	} srt_cmd_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} srt_status_t;

	// input word as it arrives on the command port
	typedef struct packed {
		srt_cmd_t    command;
		logic [11:0] pos_x;
		logic [11:0] pos_y;
		logic [11:0] square_size;
		logic [7:0]  square_color;
	} srt_in_t;

	// result word
	typedef struct packed {
		srt_status_t status;
		logic [11:0] removed_size;
		logic [7:0]  removed_color;
		logic [6:0]  entry_count;
	} srt_out_t;

	// one stored record
	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [11:0]           size;
		logic [7:0]            color;
	} srt_rec_t;

	// operation broadcast to every cell
	typedef struct packed {
		logic     do_insert;
		logic     do_remove;
		srt_rec_t rec;
	} srt_op_t;

	// flags a cell hands to its neighbours and to the top level
	typedef struct packed {
		logic at;     // insert slot is at or before this cell
		logic ge;     // holds a record whose key is not below the probe key
		logic match;  // holds a record with exactly the probe key
		logic valid;
	} srt_flags_t;

endpackage

>>> hw/rtl/srt_cell.sv
// srt_cell: one slot of the sorted chain, holding a record and its valid bit
// depends on srt_pkg
module srt_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                is_first,
	input  logic                at_head,
	input  srt_pkg::srt_op_t    op,
	input  srt_pkg::srt_flags_t left_flags,
	input  srt_pkg::srt_rec_t   left_rec,
	input  logic                right_valid,
	input  srt_pkg::srt_rec_t   right_rec,
	output srt_pkg::srt_flags_t flags,
	output srt_pkg::srt_rec_t   rec,
	output srt_pkg::srt_rec_t   sel_rec
);

	srt_pkg::srt_rec_t rec_q;
	logic              valid_q;
	logic [2*srt_pkg::COORD_BITS-1:0] own_key, probe_key;
	logic gt, ge, at, match, load_new, load_left, load_right;

	assign own_key   = {rec_q.y, rec_q.x};
	assign probe_key = {op.rec.y, op.rec.x};

	always_comb begin
		gt    = valid_q && (own_key > probe_key);
		ge    = valid_q && (own_key >= probe_key);
		match = valid_q && (own_key == probe_key);
		// head cell takes the new record when empty or when its key is strictly greater
		if (is_first) begin
			at = !valid_q || gt;
		end else begin
			at = at_head || !valid_q || ge;
		end
		load_new   = op.do_insert && at && !left_flags.at;
		load_left  = op.do_insert && left_flags.at;
		load_right = op.do_remove && ge;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_new) begin
			valid_q <= 1'b1;
		end else if (load_left) begin
			valid_q <= left_flags.valid;
		end else if (load_right) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_new) begin
			rec_q <= op.rec;
		end else if (load_left) begin
			rec_q <= left_rec;
		end else if (load_right) begin
			rec_q <= right_rec;
		end
	end

	assign flags   = '{at: at, ge: ge, match: match, valid: valid_q};
	assign rec     = rec_q;
	// first matching cell drives its record onto the removal bus
	assign sel_rec = (match && !left_flags.match) ? rec_q : '0;

endmodule

>>> hw/rtl/sorted_rectangle_table.sv
// sorted_rectangle_table: bounded table of square records kept sorted by y then x
// built from a chain of srt_cell slots; depends on srt_pkg and srt_cell
//
//  channel   | ports                 | handshake
//  ----------+-----------------------+-------------------------------------
//  command   | start, busy, request  | word taken when start && !busy
//  result    | done, result          | one-cycle strobe, always taken
//
// every command word is handled within its cycle of acceptance: its result appears on the clock edge
// after acceptance, so a new word may be given in every cycle
// busy is held low; the chain settles within the cycle of acceptance
// reset clears the valid bit of every cell and the count, table empty
// the receiver cannot stall, so each result is shown for exactly one cycle
module sorted_rectangle_table (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  srt_pkg::srt_in_t request,
	output logic             done,
	output srt_pkg::srt_out_t result
);

	localparam int N = srt_pkg::CAPACITY;

	srt_pkg::srt_op_t    op;
	srt_pkg::srt_flags_t cell_flags [N];
	srt_pkg::srt_rec_t   cell_rec   [N];
	srt_pkg::srt_rec_t   cell_sel   [N];
	srt_pkg::srt_rec_t   removed;
	logic [N-1:0]        match_vec;
	logic                found, full, is_insert, is_remove;

	logic [srt_pkg::CNT_BITS-1:0] count_q, count_next;
	srt_pkg::srt_out_t            result_q;
	logic                         done_q;

	assign busy = 1'b0;

	assign is_insert = start && (request.command == srt_pkg::CMD_INSERT);
	assign is_remove = start && (request.command == srt_pkg::CMD_REMOVE);
	assign full      = (count_q == srt_pkg::CNT_BITS'(N));

	// probe record, each coordinate cast to COORD_BITS, the coordinate width of the key
	always_comb begin
		op.rec.x     = srt_pkg::COORD_BITS'(request.pos_x);
		op.rec.y     = srt_pkg::COORD_BITS'(request.pos_y);
		op.rec.size  = request.square_size;
		op.rec.color = request.square_color;
		op.do_insert = is_insert && !full;
		op.do_remove = is_remove && found;
	end

	// the chain: each cell looks left on insert and right on remove
	for (genvar i = 0; i < N; i++) begin : g_cell
		srt_pkg::srt_flags_t lf;
		srt_pkg::srt_rec_t   lr;
		srt_pkg::srt_rec_t   rr;
		logic                rv;

		if (i == 0) begin : g_head
			assign lf = '0;
			assign lr = op.rec;
		end else begin : g_body
			assign lf = cell_flags[i-1];
			assign lr = cell_rec[i-1];
		end

		if (i == N - 1) begin : g_tail
			assign rv = 1'b0;
			assign rr = '0;
		end else begin : g_mid
			assign rv = cell_flags[i+1].valid;
			assign rr = cell_rec[i+1];
		end

		srt_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.is_first    (i == 0),
			.at_head     ((i == 0) ? 1'b0 : cell_flags[0].at),
			.op          (op),
			.left_flags  (lf),
			.left_rec    (lr),
			.right_valid (rv),
			.right_rec   (rr),
			.flags       (cell_flags[i]),
			.rec         (cell_rec[i]),
			.sel_rec     (cell_sel[i])
		);

		assign match_vec[i] = cell_flags[i].match;
	end

	assign found = |match_vec;

	// only the first matching cell drives its record; all other cells drive zero
	always_comb begin
		removed = '0;
		for (int i = 0; i < N; i++) begin
			removed = removed | cell_sel[i];
		end
	end

	always_comb begin
		count_next = count_q;
		if (op.do_insert) begin
			count_next = count_q + 1'b1;
		end else if (op.do_remove) begin
			count_next = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_next;
			done_q  <= start;
		end
	end

	// result word, payload only
	always_ff @(posedge clk) begin
		if (start) begin
			result_q.status        <= srt_pkg::ST_DONE;
			result_q.removed_size  <= '0;
			result_q.removed_color <= '0;
			result_q.entry_count   <= 7'(count_next);
			if (is_insert && full) begin
				result_q.status <= srt_pkg::ST_FULL;
			end else if (is_remove && !found) begin
				result_q.status <= srt_pkg::ST_NOT_FOUND;
			end else if (is_remove) begin
				result_q.removed_size  <= removed.size;
				result_q.removed_color <= removed.color;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
